@@ design/cubic_bezier_segment_generator_defines.svh @@
// Assertion macros for the cubic Bezier segment generator RTL.
`ifndef CUBIC_BEZIER_SEGMENT_GENERATOR_DEFINES_SVH
`define CUBIC_BEZIER_SEGMENT_GENERATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, quiet while rst_ni is low
`define CBSG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, quiet while rst_ni is low
`define CBSG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/cbsg_pkg.sv @@
// Shared widths, constants and types of the cubic Bezier segment generator.
package cbsg_pkg;

  // Coordinate and fixed-point formats
  localparam int COORD_WIDTH = 16;
  localparam int FRAC_BITS   = 16;
  localparam int FX_WIDTH    = COORD_WIDTH + FRAC_BITS;
  localparam int DIFF_WIDTH  = FX_WIDTH + 1;
  localparam int T_WIDTH     = FRAC_BITS + 1;
  localparam int PROD_WIDTH  = FX_WIDTH + T_WIDTH;

  // Point count limits
  localparam int MAX_POINTS  = 65;
  localparam int MAX_SPAN    = MAX_POINTS - 1;
  localparam int CNT_WIDTH   = 7;
  localparam int SPAN_WIDTH  = $clog2(MAX_SPAN + 1);
  localparam int REM_WIDTH   = $clog2(MAX_SPAN);

  // Step divider: one quotient bit per cycle
  localparam int DIV_STEPS     = T_WIDTH;
  localparam int DIV_CNT_WIDTH = $clog2(DIV_STEPS);

  // Pipeline shape: three stages per interpolation level, one for rounding
  localparam int LERP_STAGES = 3;
  localparam int PIPE_DEPTH  = 3 * LERP_STAGES + 1;

  localparam logic [T_WIDTH-1:0]    T_ONE      = T_WIDTH'(1 << FRAC_BITS);
  localparam logic [T_WIDTH-1:0]    RESET_QUOT = T_WIDTH'((1 << FRAC_BITS) / MAX_SPAN);
  localparam logic [REM_WIDTH-1:0]  RESET_REM  = REM_WIDTH'((1 << FRAC_BITS) % MAX_SPAN);
  localparam logic [SPAN_WIDTH-1:0] RESET_SPAN = SPAN_WIDTH'(MAX_SPAN);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [FX_WIDTH-1:0]    fx_t;
  typedef logic [T_WIDTH-1:0]            t_t;

  // Per-step increment of t: quotient and remainder of one over the span
  typedef struct packed {
    t_t                   quot;
    logic [REM_WIDTH-1:0] rem;
  } div_res_t;

  // Control travelling alongside each point in the pipeline
  typedef struct packed {
    logic valid;
    logic last;
  } pipe_ctl_t;

endpackage

@@ design/cbsg_t_div.sv @@
// Restoring divider giving 2^16 / span and its remainder, one bit per cycle.
module cbsg_t_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [cbsg_pkg::SPAN_WIDTH-1:0] divisor_i,
  output logic                           busy_o,
  output cbsg_pkg::div_res_t             res_o
);

  logic                               busy_q;
  logic [cbsg_pkg::DIV_CNT_WIDTH-1:0] cnt_q;
  logic [cbsg_pkg::SPAN_WIDTH-1:0]    rem_q, rem_d;
  cbsg_pkg::t_t                       quot_q;
  logic                               num_bit;
  logic [cbsg_pkg::SPAN_WIDTH:0]      shifted;
  logic                               fits;

  // One restoring step; the numerator is a single one in its top bit
  always_comb begin
    num_bit = (cnt_q == cbsg_pkg::DIV_CNT_WIDTH'(cbsg_pkg::DIV_STEPS - 1));
    shifted = {rem_q, num_bit};
    fits    = (shifted >= (cbsg_pkg::SPAN_WIDTH + 1)'(divisor_i));
    if (fits) begin
      rem_d = cbsg_pkg::SPAN_WIDTH'(shifted - (cbsg_pkg::SPAN_WIDTH + 1)'(divisor_i));
    end else begin
      rem_d = cbsg_pkg::SPAN_WIDTH'(shifted);
    end
  end

  // Iteration control; reset values match the reset point count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= cbsg_pkg::SPAN_WIDTH'(cbsg_pkg::RESET_REM);
      quot_q <= cbsg_pkg::RESET_QUOT;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= cbsg_pkg::DIV_CNT_WIDTH'(cbsg_pkg::DIV_STEPS - 1);
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      quot_q <= {quot_q[cbsg_pkg::T_WIDTH-2:0], fits};
      rem_q  <= rem_d;
      cnt_q  <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign busy_o     = busy_q;
  assign res_o.quot = quot_q;
  assign res_o.rem  = rem_q[cbsg_pkg::REM_WIDTH-1:0];

endmodule

@@ design/cbsg_lerp.sv @@
// Three-stage fixed-point linear interpolation a + sign(b-a)*((|b-a|*t)>>16).
module cbsg_lerp (
  input  logic              clk_i,
  input  logic              en_i,
  input  cbsg_pkg::fx_t     a_i,
  input  cbsg_pkg::fx_t     b_i,
  input  cbsg_pkg::t_t      t_i,
  output cbsg_pkg::fx_t     y_o
);

  logic signed [cbsg_pkg::DIFF_WIDTH-1:0] d_pos, d_neg;
  logic [cbsg_pkg::FX_WIDTH-1:0]          mag_d, mag_q;
  logic [cbsg_pkg::PROD_WIDTH-1:0]        prod;
  logic [cbsg_pkg::FX_WIDTH-1:0]          p_q;
  logic                                   neg1_q, neg2_q;
  cbsg_pkg::fx_t                          a1_q, a2_q, y_q;
  cbsg_pkg::t_t                           t1_q;

  // Stage 1: difference both ways, keep magnitude and sign
  always_comb begin
    d_pos = cbsg_pkg::DIFF_WIDTH'(b_i) - cbsg_pkg::DIFF_WIDTH'(a_i);
    d_neg = cbsg_pkg::DIFF_WIDTH'(a_i) - cbsg_pkg::DIFF_WIDTH'(b_i);
    mag_d = d_pos[cbsg_pkg::DIFF_WIDTH-1] ? d_neg[cbsg_pkg::FX_WIDTH-1:0]
                                          : d_pos[cbsg_pkg::FX_WIDTH-1:0];
  end

  // Stage 2: magnitude times t, dropping the fraction
  assign prod = cbsg_pkg::PROD_WIDTH'(mag_q) * cbsg_pkg::PROD_WIDTH'(t1_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q  <= mag_d;
      neg1_q <= d_pos[cbsg_pkg::DIFF_WIDTH-1];
      a1_q   <= a_i;
      t1_q   <= t_i;
      p_q    <= prod[cbsg_pkg::FRAC_BITS +: cbsg_pkg::FX_WIDTH];
      neg2_q <= neg1_q;
      a2_q   <= a1_q;
      // Stage 3: apply the truncated step from a
      y_q    <= neg2_q ? (a2_q - $signed(p_q)) : (a2_q + $signed(p_q));
    end
  end

  assign y_o = y_q;

endmodule

@@ design/cbsg_bezier_pipe.sv @@
// De Casteljau evaluation pipeline for both axes, ending in truncation to pixels.
module cbsg_bezier_pipe (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  cbsg_pkg::pipe_ctl_t   in_ctl_i,
  input  cbsg_pkg::t_t          t_i,
  // Control points per axis (0: x, 1: y), ordered P0, P1, P2, P3
  input  cbsg_pkg::coord_t      pts_i [2][4],
  output cbsg_pkg::pipe_ctl_t   out_ctl_o,
  output cbsg_pkg::coord_t      pix_o [2]
);

  cbsg_pkg::pipe_ctl_t ctl_q [cbsg_pkg::PIPE_DEPTH];
  cbsg_pkg::t_t        t_q   [2 * cbsg_pkg::LERP_STAGES];
  cbsg_pkg::fx_t       lvl0  [2][4];
  cbsg_pkg::fx_t       lvl1  [2][3];
  cbsg_pkg::fx_t       lvl2  [2][2];
  cbsg_pkg::fx_t       lvl3  [2];
  cbsg_pkg::coord_t    pix_q [2];

  // Control shift line, in step with the data stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < cbsg_pkg::PIPE_DEPTH; i++) begin
        ctl_q[i] <= '0;
      end
    end else if (en_i) begin
      ctl_q[0] <= in_ctl_i;
      for (int i = 1; i < cbsg_pkg::PIPE_DEPTH; i++) begin
        ctl_q[i] <= ctl_q[i-1];
      end
    end
  end

  // t delay line feeding the second and third levels
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q[0] <= t_i;
      for (int i = 1; i < 2 * cbsg_pkg::LERP_STAGES; i++) begin
        t_q[i] <= t_q[i-1];
      end
    end
  end

  for (genvar ax = 0; ax < 2; ax++) begin : g_axis
    // Whole pixels to fixed point
    for (genvar i = 0; i < 4; i++) begin : g_fx
      assign lvl0[ax][i] = $signed({pts_i[ax][i], {cbsg_pkg::FRAC_BITS{1'b0}}});
    end

    for (genvar i = 0; i < 3; i++) begin : g_lvl1
      cbsg_lerp u_lerp (
        .clk_i (clk_i),
        .en_i  (en_i),
        .a_i   (lvl0[ax][i]),
        .b_i   (lvl0[ax][i+1]),
        .t_i   (t_i),
        .y_o   (lvl1[ax][i])
      );
    end

    for (genvar i = 0; i < 2; i++) begin : g_lvl2
      cbsg_lerp u_lerp (
        .clk_i (clk_i),
        .en_i  (en_i),
        .a_i   (lvl1[ax][i]),
        .b_i   (lvl1[ax][i+1]),
        .t_i   (t_q[cbsg_pkg::LERP_STAGES-1]),
        .y_o   (lvl2[ax][i])
      );
    end

    cbsg_lerp u_lerp3 (
      .clk_i (clk_i),
      .en_i  (en_i),
      .a_i   (lvl2[ax][0]),
      .b_i   (lvl2[ax][1]),
      .t_i   (t_q[2*cbsg_pkg::LERP_STAGES-1]),
      .y_o   (lvl3[ax])
    );

    // Truncate toward zero: bias negatives by one pixel less one lsb
    cbsg_pkg::fx_t bias, biased;
    assign bias   = lvl3[ax][cbsg_pkg::FX_WIDTH-1]
                    ? cbsg_pkg::fx_t'((1 << cbsg_pkg::FRAC_BITS) - 1) : '0;
    assign biased = lvl3[ax] + bias;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pix_q[ax] <= biased[cbsg_pkg::FX_WIDTH-1:cbsg_pkg::FRAC_BITS];
      end
    end

    assign pix_o[ax] = pix_q[ax];
  end

  assign out_ctl_o = ctl_q[cbsg_pkg::PIPE_DEPTH-1];

endmodule

@@ design/cubic_bezier_segment_generator.sv @@
// Cubic Bezier flattener: step sequencer, evaluation pipeline and segment output.
//
//  channel  | direction | beat contents
//  ---------+-----------+------------------------------------------------------
//  s_axis   | in        | one curve: start, end, ctrl0, ctrl1 (x then y each)
//  m_axis   | out       | one segment: from x/y, to x/y; tlast on final segment
//  cfg      | in        | point_count write, no read-back
//
//  A curve of n points issues n - 1 steps, which pass through the ten-stage evaluation
//  pipeline and the output register before the next curve can be accepted.
//  One curve is in flight at a time; s_axis_tready drops until its last beat leaves.
//  A point_count write starts the step divider; no curve is taken meanwhile.
//  After reset the block is ready at once (65 points). A stall on m_axis freezes
//  the whole pipeline.
`include "cubic_bezier_segment_generator_defines.svh"

module cubic_bezier_segment_generator (
  input  logic          clk_i,
  input  logic          rst_ni,
  // Configuration
  input  logic          cfg_we_i,
  input  logic [6:0]    cfg_wdata_i,     // point_count
  // Curve input
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [127:0]  s_axis_tdata,    // start_x, start_y, end_x, end_y,
                                         // ctrl0_x, ctrl0_y, ctrl1_x, ctrl1_y
  // Segment output
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [63:0]   m_axis_tdata,    // seg_from_x, seg_from_y, seg_to_x, seg_to_y
  output logic          m_axis_tlast     // last_segment
);

  localparam int CW = cbsg_pkg::COORD_WIDTH;

  logic                              busy_q, issuing_q;
  logic [cbsg_pkg::CNT_WIDTH-1:0]    k_q, k_next;
  cbsg_pkg::t_t                      q_q, t_issue;
  logic [cbsg_pkg::REM_WIDTH-1:0]    r_q, r_next;
  logic [cbsg_pkg::SPAN_WIDTH-1:0]   span_q, span_d, r_sum;
  logic                              r_wrap;
  logic                              div_busy;
  cbsg_pkg::div_res_t                div_res;
  logic                              in_accept, issue, issue_last, en;
  cbsg_pkg::coord_t                  pts_q [2][4];
  cbsg_pkg::coord_t                  prev_q [2];
  cbsg_pkg::coord_t                  pix [2];
  cbsg_pkg::pipe_ctl_t               pipe_in, pipe_out;
  logic                              out_valid_q, out_last_q;
  cbsg_pkg::coord_t                  from_q [2], to_q [2];

  // Clamp the written point count and turn it into a span
  always_comb begin
    if (cfg_wdata_i < cbsg_pkg::CNT_WIDTH'(2)) begin
      span_d = cbsg_pkg::SPAN_WIDTH'(1);
    end else if (cfg_wdata_i > cbsg_pkg::CNT_WIDTH'(cbsg_pkg::MAX_POINTS)) begin
      span_d = cbsg_pkg::RESET_SPAN;
    end else begin
      span_d = cbsg_pkg::SPAN_WIDTH'(cfg_wdata_i - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_q <= cbsg_pkg::RESET_SPAN;
    end else if (cfg_we_i) begin
      span_q <= span_d;
    end
  end

  // Divisor is the registered span, steady for the whole division
  cbsg_t_div u_t_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cfg_we_i),
    .divisor_i (span_q),
    .busy_o    (div_busy),
    .res_o     (div_res)
  );

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !busy_q && !div_busy;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // Next t: add the per-step quotient and carry the remainder
  always_comb begin
    r_sum      = cbsg_pkg::SPAN_WIDTH'(r_q) + cbsg_pkg::SPAN_WIDTH'(div_res.rem);
    r_wrap     = (r_sum >= span_q);
    r_next     = r_wrap ? cbsg_pkg::REM_WIDTH'(r_sum - span_q)
                        : cbsg_pkg::REM_WIDTH'(r_sum);
    t_issue    = q_q + div_res.quot + cbsg_pkg::T_WIDTH'(r_wrap);
    k_next     = k_q + 1'b1;
    issue      = issuing_q && en;
    issue_last = (k_next == cbsg_pkg::CNT_WIDTH'(span_q));
  end

  // Step sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      issuing_q <= 1'b0;
      k_q       <= '0;
      q_q       <= '0;
      r_q       <= '0;
    end else if (in_accept) begin
      busy_q    <= 1'b1;
      issuing_q <= 1'b1;
      k_q       <= '0;
      q_q       <= '0;
      r_q       <= cbsg_pkg::REM_WIDTH'(span_q >> 1);
    end else begin
      if (issue) begin
        k_q <= k_next;
        q_q <= t_issue;
        r_q <= r_next;
        if (issue_last) begin
          issuing_q <= 1'b0;
        end
      end
      if (m_axis_tvalid && m_axis_tready && m_axis_tlast) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Curve capture, held for the whole curve
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pts_q[0][0] <= s_axis_tdata[0*CW +: CW];
      pts_q[1][0] <= s_axis_tdata[1*CW +: CW];
      pts_q[0][3] <= s_axis_tdata[2*CW +: CW];
      pts_q[1][3] <= s_axis_tdata[3*CW +: CW];
      pts_q[0][1] <= s_axis_tdata[4*CW +: CW];
      pts_q[1][1] <= s_axis_tdata[5*CW +: CW];
      pts_q[0][2] <= s_axis_tdata[6*CW +: CW];
      pts_q[1][2] <= s_axis_tdata[7*CW +: CW];
    end
  end

  assign pipe_in.valid = issuing_q;
  assign pipe_in.last  = issue_last;

  cbsg_bezier_pipe u_pipe (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .in_ctl_i  (pipe_in),
    .t_i       (t_issue),
    .pts_i     (pts_q),
    .out_ctl_o (pipe_out),
    .pix_o     (pix)
  );

  // Output register and previous point
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      prev_q[0]   <= '0;
      prev_q[1]   <= '0;
    end else if (in_accept) begin
      prev_q[0] <= s_axis_tdata[0*CW +: CW];
      prev_q[1] <= s_axis_tdata[1*CW +: CW];
    end else if (en) begin
      out_valid_q <= pipe_out.valid;
      if (pipe_out.valid) begin
        prev_q[0] <= pix[0];
        prev_q[1] <= pix[1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && pipe_out.valid) begin
      from_q[0]  <= prev_q[0];
      from_q[1]  <= prev_q[1];
      to_q[0]    <= pix[0];
      to_q[1]    <= pix[1];
      out_last_q <= pipe_out.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {to_q[1], to_q[0], from_q[1], from_q[0]};
  assign m_axis_tlast  = out_last_q;

  // Checks
  `CBSG_ASSERT_NOW(a_k_in_span, issuing_q, (k_q < cbsg_pkg::CNT_WIDTH'(span_q)),
                   "step index ran past the span")
  `CBSG_ASSERT_NOW(a_last_t_one, (issue && issue_last), (t_issue == cbsg_pkg::T_ONE),
                   "final step of a curve does not reach t of one")
  `CBSG_ASSERT_NOW(a_out_in_curve, m_axis_tvalid, busy_q,
                   "segment beat outside a curve")
  `CBSG_ASSERT_NEXT(a_done_idle, (m_axis_tvalid && m_axis_tready && m_axis_tlast),
                    (!busy_q && !issuing_q), "curve not closed after its last beat")

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the cubic Bezier segment generator.
module tb_top;
  import cbsg_pkg::*;

  localparam int     N_RANDOM    = 480;
  localparam int     PHASE_LEN   = 60;
  localparam int     CYCLE_LIMIT = 400000;
  localparam int     HOLD_AT     = 120;
  localparam int     HOLD_CYCLES = 300;
  localparam int     DRAIN_WAIT  = 30;
  localparam longint ONE_Q16     = 65536;

  typedef struct {
    coord_t sx, sy, ex, ey, c0x, c0y, c1x, c1y;
  } curve_t;

  typedef struct {
    coord_t from_x, from_y, to_x, to_y;
    logic   last;
  } seg_t;

  typedef struct {
    bit         wr;
    logic [6:0] cnt;
    curve_t     c;
    bit         typed;
    seg_t       seg;
  } row_t;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         cfg_we_i      = 1'b0;
  logic [6:0]   cfg_wdata_i   = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata  = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;
  logic         m_axis_tlast;

  // Predictor state and the segments still owed by the block
  logic [6:0] pt_count = 7'd65;
  coord_t     prev_x, prev_y;
  seg_t       pending_segs[$];
  row_t       dir_rows[$];
  int         fail_cnt    = 0;
  int         curves_sent = 0;
  bit         no_idle     = 1'b0;

  cubic_bezier_segment_generator DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #10 clk_i = ~clk_i;

  // Interpolation with the product truncated toward zero; exact at t = 1
  function automatic longint lerp_q16(input longint a, input longint b, input longint t);
    longint d, mag, p;
    d   = b - a;
    mag = (d < 0) ? -d : d;
    p   = (t >= ONE_Q16) ? mag : ((mag * t) >>> FRAC_BITS);
    return (d < 0) ? a - p : a + p;
  endfunction

  function automatic longint to_whole(input longint v);
    return (v < 0) ? -((-v) >>> FRAC_BITS) : (v >>> FRAC_BITS);
  endfunction

  // Three de Casteljau levels on one axis
  function automatic coord_t curve_axis(input coord_t p0, input coord_t p1, input coord_t p2,
                                        input coord_t p3, input longint t);
    longint a0, a1, a2, a3, m0, m1, m2, b0, b1;
    a0 = longint'(p0) * ONE_Q16;
    a1 = longint'(p1) * ONE_Q16;
    a2 = longint'(p2) * ONE_Q16;
    a3 = longint'(p3) * ONE_Q16;
    m0 = lerp_q16(a0, a1, t);
    m1 = lerp_q16(a1, a2, t);
    m2 = lerp_q16(a2, a3, t);
    b0 = lerp_q16(m0, m1, t);
    b1 = lerp_q16(m1, m2, t);
    return coord_t'(to_whole(lerp_q16(b0, b1, t)));
  endfunction

  // Flatten one curve into its segments and queue them
  function automatic void flatten_curve(input curve_t c);
    int     n, span;
    longint t;
    coord_t px, py;
    seg_t   s;
    n = pt_count;
    if (n < 2) n = 2;
    if (n > MAX_POINTS) n = MAX_POINTS;
    span   = n - 1;
    prev_x = c.sx;
    prev_y = c.sy;
    for (int k = 1; k <= span; k++) begin
      t  = (longint'(k) * ONE_Q16 + span / 2) / span;
      px = curve_axis(c.sx, c.c0x, c.c1x, c.ex, t);
      py = curve_axis(c.sy, c.c0y, c.c1y, c.ey, t);
      s  = '{prev_x, prev_y, px, py, k == span};
      pending_segs.insert(pending_segs.size(), s);
      prev_x = px;
      prev_y = py;
    end
  endfunction

  task automatic add_row(input bit wr, input int cnt, input int sx, input int sy,
                         input int ex, input int ey, input int c0x, input int c0y,
                         input int c1x, input int c1y, input bit typed,
                         input int fx, input int fy, input int tx, input int ty);
    row_t r;
    r.wr    = wr;
    r.cnt   = 7'(cnt);
    r.c     = '{coord_t'(sx), coord_t'(sy), coord_t'(ex), coord_t'(ey),
                coord_t'(c0x), coord_t'(c0y), coord_t'(c1x), coord_t'(c1y)};
    r.typed = typed;
    r.seg   = '{coord_t'(fx), coord_t'(fy), coord_t'(tx), coord_t'(ty), 1'b1};
    dir_rows.insert(dir_rows.size(), r);
  endtask

  // Register write, only once every owed segment has left the block
  task automatic write_point_count(input logic [6:0] v);
    s_axis_tvalid <= 1'b0;
    while (pending_segs.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    pt_count     = v;
  endtask

  // Offer one curve beat, with an occasional gap of junk data first
  task automatic send_curve(input curve_t c, input bit typed, input seg_t seg);
    if (!no_idle && $urandom_range(99) < 26) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= {$urandom, $urandom, $urandom, $urandom};
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {c.c1y, c.c1x, c.c0y, c.c0x, c.ey, c.ex, c.sy, c.sx};
    do @(posedge clk_i); while (!s_axis_tready);
    if (typed) pending_segs.insert(pending_segs.size(), seg);
    else flatten_curve(c);
    curves_sent++;
  endtask

  function automatic coord_t pick_corner();
    case ($urandom_range(0, 4))
      0:       return coord_t'(-32768);
      1:       return coord_t'(32767);
      2:       return coord_t'(0);
      3:       return coord_t'(-1);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Stimulus: directed rows, then random phases at several point counts
  initial begin : stimulus
    curve_t     c;
    seg_t       none;
    int         cx, cy, mode;
    logic [6:0] phase_cnt;
    none = '{default: '0};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset setting (65 points), corner to corner
    add_row(0,   0, -32768,  32767,  32767, -32768,  32767,  32767, -32768, -32768,
            0, 0, 0, 0, 0);
    // two points: the one segment joins start to end
    add_row(1,   2, -32768, -32768,  32767,  32767,  12345,  -4321,   -999,  31000,
            1, -32768, -32768, 32767, 32767);
    add_row(0,   0,  32767,  32767, -32768, -32768, -32768,  32767,  32767, -32768,
            1, 32767, 32767, -32768, -32768);
    // counts below two act as two
    add_row(1,   0,    100,   -200,   -300,    400,      7,     -7,     50,    -50,
            1, 100, -200, -300, 400);
    add_row(1,   1,      0,      0,     -1,      1,  32767, -32768, -32768,  32767,
            1, 0, 0, -1, 1);
    // three points, truncation toward zero near the origin
    add_row(1,   3,     -1,      1,      1,     -1,     -1,      1,      1,     -1,
            0, 0, 0, 0, 0);
    add_row(0,   0,      0,      0,    100,    100,      0,    100,    100,      0,
            0, 0, 0, 0, 0);
    // degenerate curve: zero-length segments
    add_row(1,   3,   1234,  -4321,   1234,  -4321,   1234,  -4321,   1234,  -4321,
            0, 0, 0, 0, 0);
    // counts above the cap act as 65; then a count of 64
    add_row(1, 127, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
            0, 0, 0, 0, 0);
    add_row(1,  66,  32767, -32768, -32768,  32767,  32767, -32768, -32768,  32767,
            0, 0, 0, 0, 0);
    add_row(1,  64,     -3,     -7,      2,      5,     -1,      1,      1,     -1,
            0, 0, 0, 0, 0);
    // closed loop: start equals end
    add_row(1,  65,      0,      0,      0,      0,  32767,  32767, -32768,  32767,
            0, 0, 0, 0, 0);
    add_row(1,   2,  32767,  32767,  32767,  32767,  32767,  32767,  32767,  32767,
            1, 32767, 32767, 32767, 32767);
    add_row(1,   5,  -5000,  20000,  30000, -25000, -32768,      0,  32767,      0,
            0, 0, 0, 0, 0);
    add_row(1,  17,    -10,    -10,     10,     10,    -20,     20,     20,    -20,
            0, 0, 0, 0, 0);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].wr) write_point_count(dir_rows[i].cnt);
      send_curve(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].seg);
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % PHASE_LEN == 0) begin
        case (i / PHASE_LEN)
          0:       phase_cnt = 7'd65;
          1:       phase_cnt = 7'd2;
          2:       phase_cnt = 7'($urandom_range(3, 9));
          3:       phase_cnt = 7'd1;
          4:       phase_cnt = 7'($urandom_range(0, 127));
          5:       phase_cnt = 7'd127;
          6:       phase_cnt = 7'($urandom_range(10, 64));
          default: phase_cnt = 7'd0;
        endcase
        write_point_count(phase_cnt);
      end
      // long stretch with both sides busy every cycle
      no_idle <= (i >= 300 && i < 380);

      mode = $urandom_range(0, 3);
      case (mode)
        0: begin
          c = '{coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                coord_t'($urandom), coord_t'($urandom)};
        end
        1: begin
          cx = int'($urandom_range(0, 60000)) - 30000;
          cy = int'($urandom_range(0, 60000)) - 30000;
          c = '{coord_t'(cx + int'($urandom_range(0, 1000)) - 500),
                coord_t'(cy + int'($urandom_range(0, 1000)) - 500),
                coord_t'(cx + int'($urandom_range(0, 1000)) - 500),
                coord_t'(cy + int'($urandom_range(0, 1000)) - 500),
                coord_t'(cx + int'($urandom_range(0, 1000)) - 500),
                coord_t'(cy + int'($urandom_range(0, 1000)) - 500),
                coord_t'(cx + int'($urandom_range(0, 1000)) - 500),
                coord_t'(cy + int'($urandom_range(0, 1000)) - 500)};
        end
        2: begin
          cx = $urandom;
          cy = $urandom;
          c = '{coord_t'(cx), coord_t'(cy), coord_t'(cx), coord_t'(cy),
                coord_t'(cx), coord_t'(cy), coord_t'(cx), coord_t'(cy)};
        end
        default: begin
          c = '{pick_corner(), pick_corner(), pick_corner(), pick_corner(),
                pick_corner(), pick_corner(), pick_corner(), pick_corner()};
        end
      endcase
      send_curve(c, 1'b0, none);
    end

    // drain, then allow for the pipeline depth before the verdict
    s_axis_tvalid <= 1'b0;
    while (pending_segs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Segment sink: checks each beat, drives tready with random and long stalls
  initial begin : segment_sink
    seg_t want, got;
    int   hold_left;
    bit   hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[47:32],
                m_axis_tdata[63:48], m_axis_tlast};
        if (pending_segs.size() == 0) begin
          $display("%0t: unexpected segment (%0d,%0d)->(%0d,%0d) last %0b", $time,
                   got.from_x, got.from_y, got.to_x, got.to_y, got.last);
          fail_cnt++;
        end else begin
          want = pending_segs.pop_front();
          if (got.from_x !== want.from_x || got.from_y !== want.from_y ||
              got.to_x !== want.to_x || got.to_y !== want.to_y ||
              got.last !== want.last) begin
            $display("%0t: expected (%0d,%0d)->(%0d,%0d) %0b, got (%0d,%0d)->(%0d,%0d) %0b",
                     $time, want.from_x, want.from_y, want.to_x, want.to_y, want.last,
                     got.from_x, got.from_y, got.to_x, got.to_y, got.last);
            fail_cnt++;
          end
        end
      end
      // one long hold-off while curves keep coming, so the input backs up
      if (!hold_done && curves_sent >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= no_idle || ($urandom_range(99) >= 26);
      end
    end
  end

  // Watchdog on total run length
  initial begin : watchdog
    int cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Test completed with failures");
    $finish;
  end

endmodule
